>>> hdl/dpd_pkg.sv
package dpd_pkg;

   localparam int MAX_CLASSES = 128;
   localparam int MAX_ANCHORS = 16384;

   localparam int SCORE_W  = 16;
   localparam int COORD_W  = 16;
   localparam int LABEL_W  = $clog2(MAX_CLASSES);
   localparam int CLASS_W  = $clog2(MAX_CLASSES + 1);
   localparam int ANCHOR_W = $clog2(MAX_ANCHORS);
   localparam int RATIO_W  = 16;
   localparam int PIXEL_W  = 13;
   localparam int FRAC_W   = 4;
   localparam int EDGE_W   = PIXEL_W + FRAC_W;
   localparam int CSR_W    = 16;

   // Edge before scaling, Q13.5: 2 * centre plus size needs two bits more than a coordinate.
   localparam int EDGE_V_W = COORD_W + 2;
   localparam int PROD_W   = EDGE_V_W + RATIO_W;
   // Q17.17 product down to Q13.4.
   localparam int ROUND_SHIFT = 13;
   localparam int SCALED_W    = PROD_W - ROUND_SHIFT;
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (ROUND_SHIFT - 1);

   localparam logic [ANCHOR_W-1:0] LAST_ANCHOR = ANCHOR_W'(MAX_ANCHORS - 1);
   localparam logic [CLASS_W-1:0]  CLASS_LIMIT = CLASS_W'(MAX_CLASSES);

   typedef enum logic [1:0] {
      CSR_SCORE_THRESHOLD = 2'd0,
      CSR_SCALE_RATIO     = 2'd1,
      CSR_IMAGE_WIDTH     = 2'd2,
      CSR_IMAGE_HEIGHT    = 2'd3
   } csr_index_type;

   localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 16'd16384;
   localparam logic [RATIO_W-1:0] RATIO_RESET     = 16'd4096;
   localparam logic [PIXEL_W-1:0] WIDTH_RESET     = 13'd640;
   localparam logic [PIXEL_W-1:0] HEIGHT_RESET    = 13'd640;

   typedef struct packed {
      logic product_load;
      logic result_load;
   } adv_type;

endpackage

>>> hdl/dpd_edge.sv
module dpd_edge (
   input  logic                          clock,
   input  dpd_pkg::adv_type              adv,
   input  logic [dpd_pkg::EDGE_V_W-1:0]  edge_value,
   input  logic [dpd_pkg::RATIO_W-1:0]   ratio,
   input  logic [dpd_pkg::PIXEL_W-1:0]   limit_px,
   output logic [dpd_pkg::EDGE_W-1:0]    edge_out
);
   import dpd_pkg::*;

   logic [PROD_W-1:0]   product_ff;
   logic [PROD_W-1:0]   product_in;
   logic [EDGE_W-1:0]   edge_ff;
   logic [EDGE_W-1:0]   edge_in;
   logic [PROD_W-1:0]   rounded;
   logic [SCALED_W-1:0] scaled;
   logic [EDGE_W-1:0]   limit;

   assign product_in = PROD_W'(edge_value) * PROD_W'(ratio);

   always_comb begin
      rounded = product_ff + ROUND_BIAS;
      scaled  = rounded[PROD_W-1:ROUND_SHIFT];
      limit   = {limit_px, FRAC_W'(0)};
      if (scaled >= SCALED_W'(limit)) begin
         edge_in = limit;
      end else begin
         edge_in = scaled[EDGE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.product_load) begin
         product_ff <= product_in;
      end
      if (adv.result_load) begin
         edge_ff <= edge_in;
      end
   end

   assign edge_out = edge_ff;

endmodule

>>> hdl/detection_proposal_decode.sv
// Detection proposal decoder.
// Input channel (req_): one class score per transaction. The transaction with
// req_first_of_anchor set also carries the anchor's centre box, and with
// req_start_of_frame set it restarts anchor numbering. The transaction with
// req_last_of_anchor set closes the anchor.
// Result channel (rsp_): one transaction per anchor whose best score is above
// the threshold: the scaled, clamped corner box, the label, the score and the
// anchor number. Anchors that fall short produce nothing.
// Throughput is one input transaction per cycle while req_stall is low. A result
// reaches rsp_valid through three registers after its closing input transaction
// is accepted. The first register holds the state update and edge sums, the
// second the products of the four 18 x 16 bit multipliers, and the third the
// rounded, clamped edges.
// Registers are written through csr_; the user must do so only while no anchor
// is in flight, which the block itself does not enforce. Reset restores the
// register defaults and clears the running anchor state and all pipeline
// valids. When rsp_stall is held, the result stays on the rsp_ ports and the
// pipeline fills; req_stall rises only when all three stages hold results.
module detection_proposal_decode (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dpd_pkg::COORD_W-1:0]     req_center_x,
   input  logic [dpd_pkg::COORD_W-1:0]     req_center_y,
   input  logic [dpd_pkg::COORD_W-1:0]     req_box_width,
   input  logic [dpd_pkg::COORD_W-1:0]     req_box_height,
   input  logic [dpd_pkg::SCORE_W-1:0]     req_class_score,
   input  logic                            req_first_of_anchor,
   input  logic                            req_last_of_anchor,
   input  logic                            req_start_of_frame,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dpd_pkg::EDGE_W-1:0]      rsp_left,
   output logic [dpd_pkg::EDGE_W-1:0]      rsp_top,
   output logic [dpd_pkg::EDGE_W-1:0]      rsp_right,
   output logic [dpd_pkg::EDGE_W-1:0]      rsp_bottom,
   output logic [dpd_pkg::LABEL_W-1:0]     rsp_class_label,
   output logic [dpd_pkg::SCORE_W-1:0]     rsp_best_score,
   output logic [dpd_pkg::ANCHOR_W-1:0]    rsp_anchor_number,
   input  logic                            csr_write_enable,
   input  dpd_pkg::csr_index_type          csr_index,
   input  logic [dpd_pkg::CSR_W-1:0]       csr_write_data
);
   import dpd_pkg::*;

   logic [SCORE_W-1:0]  threshold_ff;
   logic [RATIO_W-1:0]  ratio_ff;
   logic [PIXEL_W-1:0]  width_ff;
   logic [PIXEL_W-1:0]  height_ff;

   logic [SCORE_W-1:0]  best_ff, best_in;
   logic [LABEL_W-1:0]  label_ff, label_in;
   logic [CLASS_W-1:0]  class_ff, class_in;
   logic [COORD_W-1:0]  box_x_ff, box_y_ff, box_w_ff, box_h_ff;
   logic [COORD_W-1:0]  box_x_in, box_y_in, box_w_in, box_h_in;
   logic [ANCHOR_W-1:0] anchor_ff, anchor_in, anchor_base;

   logic                accept;
   logic                emit;
   logic [COORD_W:0]    x2, y2;
   logic [EDGE_V_W-1:0] edge_v_in [4];

   logic                s1_valid_ff, s1_valid_in;
   logic [EDGE_V_W-1:0] s1_edge_ff [4];
   logic [LABEL_W-1:0]  s1_label_ff;
   logic [SCORE_W-1:0]  s1_best_ff;
   logic [ANCHOR_W-1:0] s1_anchor_ff;

   logic                s2_valid_ff, s2_valid_in;
   logic [LABEL_W-1:0]  s2_label_ff;
   logic [SCORE_W-1:0]  s2_best_ff;
   logic [ANCHOR_W-1:0] s2_anchor_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LABEL_W-1:0]  rsp_label_ff;
   logic [SCORE_W-1:0]  rsp_best_ff;
   logic [ANCHOR_W-1:0] rsp_anchor_ff;

   logic                out_go, s2_go, s1_go;
   adv_type             adv;

   assign out_go    = !rsp_valid_ff || !rsp_stall;
   assign s2_go     = !s2_valid_ff || out_go;
   assign s1_go     = !s1_valid_ff || s2_go;
   assign req_stall = !s1_go;
   assign accept    = req_valid && s1_go;

   assign adv.product_load = s2_go;
   assign adv.result_load  = out_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         ratio_ff     <= RATIO_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCORE_THRESHOLD: threshold_ff <= csr_write_data[SCORE_W-1:0];
            CSR_SCALE_RATIO:     ratio_ff     <= csr_write_data[RATIO_W-1:0];
            CSR_IMAGE_WIDTH:     width_ff     <= csr_write_data[PIXEL_W-1:0];
            CSR_IMAGE_HEIGHT:    height_ff    <= csr_write_data[PIXEL_W-1:0];
         endcase
      end
   end

   always_comb begin
      best_in     = best_ff;
      label_in    = label_ff;
      class_in    = class_ff;
      box_x_in    = box_x_ff;
      box_y_in    = box_y_ff;
      box_w_in    = box_w_ff;
      box_h_in    = box_h_ff;
      anchor_base = anchor_ff;
      if (req_first_of_anchor) begin
         if (req_start_of_frame) begin
            anchor_base = '0;
         end
         box_x_in = req_center_x;
         box_y_in = req_center_y;
         box_w_in = req_box_width;
         box_h_in = req_box_height;
         best_in  = req_class_score;
         label_in = '0;
         class_in = CLASS_W'(1);
      end else if (class_ff < CLASS_LIMIT) begin
         if (req_class_score > best_ff) begin
            best_in  = req_class_score;
            label_in = class_ff[LABEL_W-1:0];
         end
         class_in = class_ff + CLASS_W'(1);
      end
      anchor_in = anchor_base;
      if (req_last_of_anchor) begin
         anchor_in = (anchor_base == LAST_ANCHOR) ? '0 : anchor_base + ANCHOR_W'(1);
      end
      emit = req_last_of_anchor && (best_in > threshold_ff);
   end

   always_comb begin
      x2 = {box_x_in, 1'b0};
      y2 = {box_y_in, 1'b0};
      edge_v_in[0] = (x2 <= (COORD_W + 1)'(box_w_in)) ? '0
                   : EDGE_V_W'(x2 - (COORD_W + 1)'(box_w_in));
      edge_v_in[1] = (y2 <= (COORD_W + 1)'(box_h_in)) ? '0
                   : EDGE_V_W'(y2 - (COORD_W + 1)'(box_h_in));
      edge_v_in[2] = EDGE_V_W'(x2) + EDGE_V_W'(box_w_in);
      edge_v_in[3] = EDGE_V_W'(y2) + EDGE_V_W'(box_h_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff   <= '0;
         label_ff  <= '0;
         class_ff  <= '0;
         box_x_ff  <= '0;
         box_y_ff  <= '0;
         box_w_ff  <= '0;
         box_h_ff  <= '0;
         anchor_ff <= '0;
      end else if (accept) begin
         best_ff   <= best_in;
         label_ff  <= label_in;
         class_ff  <= class_in;
         box_x_ff  <= box_x_in;
         box_y_ff  <= box_y_in;
         box_w_ff  <= box_w_in;
         box_h_ff  <= box_h_in;
         anchor_ff <= anchor_in;
      end
   end

   assign s1_valid_in  = s1_go ? (accept && emit) : s1_valid_ff;
   assign s2_valid_in  = s2_go ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = out_go ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s1_edge_ff   <= edge_v_in;
         s1_label_ff  <= label_in;
         s1_best_ff   <= best_in;
         s1_anchor_ff <= anchor_base;
      end
      if (s2_go) begin
         s2_label_ff  <= s1_label_ff;
         s2_best_ff   <= s1_best_ff;
         s2_anchor_ff <= s1_anchor_ff;
      end
      if (out_go) begin
         rsp_label_ff  <= s2_label_ff;
         rsp_best_ff   <= s2_best_ff;
         rsp_anchor_ff <= s2_anchor_ff;
      end
   end

   dpd_edge u_left (
      .clock      (clock),
      .adv        (adv),
      .edge_value (s1_edge_ff[0]),
      .ratio      (ratio_ff),
      .limit_px   (width_ff),
      .edge_out   (rsp_left)
   );

   dpd_edge u_top (
      .clock      (clock),
      .adv        (adv),
      .edge_value (s1_edge_ff[1]),
      .ratio      (ratio_ff),
      .limit_px   (height_ff),
      .edge_out   (rsp_top)
   );

   dpd_edge u_right (
      .clock      (clock),
      .adv        (adv),
      .edge_value (s1_edge_ff[2]),
      .ratio      (ratio_ff),
      .limit_px   (width_ff),
      .edge_out   (rsp_right)
   );

   dpd_edge u_bottom (
      .clock      (clock),
      .adv        (adv),
      .edge_value (s1_edge_ff[3]),
      .ratio      (ratio_ff),
      .limit_px   (height_ff),
      .edge_out   (rsp_bottom)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_class_label   = rsp_label_ff;
   assign rsp_best_score    = rsp_best_ff;
   assign rsp_anchor_number = rsp_anchor_ff;

endmodule

>>> hdl/dpd_checker.sv
module dpd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_stall,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [dpd_pkg::EDGE_W-1:0]      rsp_left,
   input  logic [dpd_pkg::EDGE_W-1:0]      rsp_top,
   input  logic [dpd_pkg::EDGE_W-1:0]      rsp_right,
   input  logic [dpd_pkg::EDGE_W-1:0]      rsp_bottom,
   input  logic [dpd_pkg::LABEL_W-1:0]     rsp_class_label,
   input  logic [dpd_pkg::SCORE_W-1:0]     rsp_best_score,
   input  logic [dpd_pkg::ANCHOR_W-1:0]    rsp_anchor_number
);
   import dpd_pkg::*;

   // The result channel is empty on the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result transaction present after reset");

   // The input side only backs up when the result side is full and stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // Scaling and clamping keep the corners in order.
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_left <= rsp_right) && (rsp_top <= rsp_bottom)))
      else $error("box corners out of order");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_left) && $stable(rsp_top)
         && $stable(rsp_right) && $stable(rsp_bottom) && $stable(rsp_class_label)
         && $stable(rsp_best_score) && $stable(rsp_anchor_number)))
      else $error("stalled result transaction changed");

endmodule

bind detection_proposal_decode dpd_checker u_dpd_checker (.*);

>>> tb/tb.sv
module tb;
   import dpd_pkg::*;

   localparam int HOLD_OFF_CYCLES = 48;
   localparam int SETTLE_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int PHASE_ITEMS     = 180;
   localparam int ANCHOR_RUN      = 100;

   typedef struct {
      logic [EDGE_W-1:0]   left;
      logic [EDGE_W-1:0]   top;
      logic [EDGE_W-1:0]   right;
      logic [EDGE_W-1:0]   bottom;
      logic [LABEL_W-1:0]  label;
      logic [SCORE_W-1:0]  score;
      logic [ANCHOR_W-1:0] anchor;
   } detection_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [COORD_W-1:0]    req_center_x = '0;
   logic [COORD_W-1:0]    req_center_y = '0;
   logic [COORD_W-1:0]    req_box_width = '0;
   logic [COORD_W-1:0]    req_box_height = '0;
   logic [SCORE_W-1:0]    req_class_score = '0;
   logic                  req_first_of_anchor = 1'b0;
   logic                  req_last_of_anchor = 1'b0;
   logic                  req_start_of_frame = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [EDGE_W-1:0]     rsp_left;
   logic [EDGE_W-1:0]     rsp_top;
   logic [EDGE_W-1:0]     rsp_right;
   logic [EDGE_W-1:0]     rsp_bottom;
   logic [LABEL_W-1:0]    rsp_class_label;
   logic [SCORE_W-1:0]    rsp_best_score;
   logic [ANCHOR_W-1:0]   rsp_anchor_number;
   logic                  csr_write_enable = 1'b0;
   csr_index_type         csr_index = CSR_SCORE_THRESHOLD;
   logic [CSR_W-1:0]      csr_write_data = '0;

   logic [SCORE_W-1:0]    score_limit = THRESHOLD_RESET;
   logic [RATIO_W-1:0]    ratio_q = RATIO_RESET;
   logic [PIXEL_W-1:0]    width_px = WIDTH_RESET;
   logic [PIXEL_W-1:0]    height_px = HEIGHT_RESET;

   logic [SCORE_W-1:0]    best_so_far = '0;
   logic [LABEL_W-1:0]    best_label = '0;
   logic [CLASS_W-1:0]    next_class = '0;
   logic [COORD_W-1:0]    held_x = '0;
   logic [COORD_W-1:0]    held_y = '0;
   logic [COORD_W-1:0]    held_w = '0;
   logic [COORD_W-1:0]    held_h = '0;
   logic [ANCHOR_W-1:0]   anchor_index = '0;

   detection_type         pending_detections[$];
   int                    error_count = 0;
   int                    items_sent = 0;
   int                    hold_offs_asked = 0;
   int                    hold_offs_done = 0;
   bit                    quiet = 1'b0;

   detection_proposal_decode dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_center_x        (req_center_x),
      .req_center_y        (req_center_y),
      .req_box_width       (req_box_width),
      .req_box_height      (req_box_height),
      .req_class_score     (req_class_score),
      .req_first_of_anchor (req_first_of_anchor),
      .req_last_of_anchor  (req_last_of_anchor),
      .req_start_of_frame  (req_start_of_frame),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_left            (rsp_left),
      .rsp_top             (rsp_top),
      .rsp_right           (rsp_right),
      .rsp_bottom          (rsp_bottom),
      .rsp_class_label     (rsp_class_label),
      .rsp_best_score      (rsp_best_score),
      .rsp_anchor_number   (rsp_anchor_number),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
   endtask

   // One corner edge in Q13.4: (2c -/+ s) * ratio, rounded half up, clamped to the image.
   function automatic logic [EDGE_W-1:0] scaled_edge(input logic [COORD_W-1:0] centre,
         input logic [COORD_W-1:0] size, input logic lower, input logic [PIXEL_W-1:0] limit_px);
      logic [63:0] span;
      logic [63:0] rounded;
      logic [63:0] limit_q;
      limit_q = 64'(limit_px) << FRAC_W;
      if (lower && (64'(centre) << 1) <= 64'(size))
         return '0;
      span = lower ? (64'(centre) << 1) - 64'(size) : (64'(centre) << 1) + 64'(size);
      rounded = (span * 64'(ratio_q) + 64'd4096) >> 13;
      if (rounded >= limit_q)
         rounded = limit_q;
      return rounded[EDGE_W-1:0];
   endfunction

   task automatic predict_detection(input logic [COORD_W-1:0] cx, cy, bw, bh,
         input logic [SCORE_W-1:0] score, input logic first, last, sof);
      detection_type d;
      if (first) begin
         if (sof)
            anchor_index = '0;
         held_x = cx;
         held_y = cy;
         held_w = bw;
         held_h = bh;
         best_so_far = score;
         best_label = '0;
         next_class = CLASS_W'(1);
      end else if (next_class < CLASS_LIMIT) begin
         if (score > best_so_far) begin
            best_so_far = score;
            best_label = next_class[LABEL_W-1:0];
         end
         next_class++;
      end
      if (last) begin
         if (best_so_far > score_limit) begin
            d.left = scaled_edge(held_x, held_w, 1'b1, width_px);
            d.top = scaled_edge(held_y, held_h, 1'b1, height_px);
            d.right = scaled_edge(held_x, held_w, 1'b0, width_px);
            d.bottom = scaled_edge(held_y, held_h, 1'b0, height_px);
            d.label = best_label;
            d.score = best_so_far;
            d.anchor = anchor_index;
            pending_detections.insert(pending_detections.size(), d);
         end
         anchor_index = (anchor_index == LAST_ANCHOR) ? '0 : anchor_index + ANCHOR_W'(1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         predict_detection(req_center_x, req_center_y, req_box_width, req_box_height,
                           req_class_score, req_first_of_anchor, req_last_of_anchor,
                           req_start_of_frame);
   end

   always @(posedge clock) begin : check_results
      detection_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_detections.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_anchor_number), 0);
         end else begin
            want = pending_detections.pop_front();
            if (rsp_left !== want.left)
               report_mismatch("left", 32'(rsp_left), 32'(want.left));
            if (rsp_top !== want.top)
               report_mismatch("top", 32'(rsp_top), 32'(want.top));
            if (rsp_right !== want.right)
               report_mismatch("right", 32'(rsp_right), 32'(want.right));
            if (rsp_bottom !== want.bottom)
               report_mismatch("bottom", 32'(rsp_bottom), 32'(want.bottom));
            if (rsp_class_label !== want.label)
               report_mismatch("class_label", 32'(rsp_class_label), 32'(want.label));
            if (rsp_best_score !== want.score)
               report_mismatch("best_score", 32'(rsp_best_score), 32'(want.score));
            if (rsp_anchor_number !== want.anchor)
               report_mismatch("anchor_number", 32'(rsp_anchor_number), 32'(want.anchor));
         end
      end
   end

   // The receiver stalls in random bursts, or for one long stretch when a hold-off is asked for.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_offs_done != hold_offs_asked) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
            hold_offs_done++;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 13)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int stuck_cycles;
      stuck_cycles = 0;
      while (stuck_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [COORD_W-1:0] random_coord();
      return $urandom_range(0, 1) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 12000));
   endfunction

   task automatic send_score(input logic [COORD_W-1:0] cx, cy, bw, bh,
         input logic [SCORE_W-1:0] score, input logic first, last, sof);
      req_center_x <= cx;
      req_center_y <= cy;
      req_box_width <= bw;
      req_box_height <= bh;
      req_class_score <= score;
      req_first_of_anchor <= first;
      req_last_of_anchor <= last;
      req_start_of_frame <= sof;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic send_single(input logic [COORD_W-1:0] cx, cy, bw, bh,
         input logic [SCORE_W-1:0] score, input logic sof);
      send_score(cx, cy, bw, bh, score, 1'b1, 1'b1, sof);
   endtask

   task automatic send_anchor(input int classes, input bit new_frame, input bit closed);
      logic [COORD_W-1:0] cx, cy, bw, bh;
      logic [SCORE_W-1:0] score, peak;
      cx = random_coord();
      cy = random_coord();
      bw = random_coord();
      bh = random_coord();
      peak = '0;
      for (int i = 0; i < classes; i++) begin
         score = ($urandom_range(0, 3) == 0) ? peak : SCORE_W'($urandom);
         if (score > peak)
            peak = score;
         if (i == 0)
            send_score(cx, cy, bw, bh, score, 1'b1, closed && classes == 1, new_frame);
         else
            send_score(random_coord(), random_coord(), random_coord(), random_coord(), score,
                       1'b0, closed && i == classes - 1, $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic send_noise_item();
      send_score(random_coord(), random_coord(), random_coord(), random_coord(),
                 SCORE_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_detections.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(input logic [SCORE_W-1:0] thr, input logic [RATIO_W-1:0] ratio,
         input logic [PIXEL_W-1:0] w, input logic [PIXEL_W-1:0] h);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SCORE_THRESHOLD;
      csr_write_data <= CSR_W'(thr);
      @(posedge clock);
      csr_index <= CSR_SCALE_RATIO;
      csr_write_data <= CSR_W'(ratio);
      @(posedge clock);
      csr_index <= CSR_IMAGE_WIDTH;
      csr_write_data <= CSR_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_write_data <= CSR_W'(h);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      score_limit = thr;
      ratio_q = ratio;
      width_px = w;
      height_px = h;
   endtask

   // Straight out of reset, items without a first mark work on the cleared state.
   task automatic test_missing_first();
      send_score(random_coord(), random_coord(), random_coord(), random_coord(), 16'h8000,
                 1'b0, 1'b1, 1'b1);
      send_score(random_coord(), random_coord(), random_coord(), random_coord(), 16'h0100,
                 1'b0, 1'b0, 1'b0);
      send_score(random_coord(), random_coord(), random_coord(), random_coord(), 16'h9000,
                 1'b0, 1'b1, 1'b0);
   endtask

   task automatic test_directed_cases();
      send_single(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_single(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_score(16'd3200, 16'd2400, 16'd800, 16'd640, 16'h5000, 1'b1, 1'b0, 1'b0);
      send_score(16'd0, 16'd0, 16'd0, 16'd0, 16'h7000, 1'b0, 1'b0, 1'b0);
      send_score(16'd0, 16'd0, 16'd0, 16'd0, 16'h7000, 1'b0, 1'b0, 1'b0);
      send_score(16'd0, 16'd0, 16'd0, 16'd0, 16'h6000, 1'b0, 1'b1, 1'b0);
      send_single(16'd4000, 16'd4000, 16'd320, 16'd320, THRESHOLD_RESET, 1'b0);
      send_single(16'd4000, 16'd4000, 16'd320, 16'd320, THRESHOLD_RESET + 16'd1, 1'b0);
      send_single(16'd16, 16'd16, 16'd1000, 16'd1000, 16'h8000, 1'b0);
      send_score(16'd5000, 16'd6000, 16'd7000, 16'd8000, 16'h1000, 1'b1, 1'b0, 1'b0);
      send_score(16'd1, 16'd2, 16'd3, 16'd4, 16'h2000, 1'b0, 1'b0, 1'b1);
      send_score(16'd1, 16'd2, 16'd3, 16'd4, 16'hFFFF, 1'b0, 1'b1, 1'b0);
   endtask

   // Scores past the class limit must not take part in the maximum.
   task automatic test_class_overflow();
      for (int k = 0; k < 2; k++)
         for (int i = 0; i < MAX_CLASSES + 3; i++)
            send_score(random_coord(), random_coord(), random_coord(), random_coord(),
                       (i == (k == 0 ? MAX_CLASSES + 1 : MAX_CLASSES - 1)) ? 16'hE000 : 16'h6000,
                       i == 0, i == MAX_CLASSES + 2, 1'b0);
   endtask

   task automatic run_register_phase(input logic [SCORE_W-1:0] thr,
         input logic [RATIO_W-1:0] ratio, input logic [PIXEL_W-1:0] w,
         input logic [PIXEL_W-1:0] h);
      wait_for_idle();
      program_registers(thr, ratio, w, h);
      send_single(random_coord(), random_coord(), random_coord(), random_coord(), 16'hFFFF,
                  1'b0);
      for (int i = 0; i < 6; i++)
         send_anchor($urandom_range(1, 4), 1'b0, 1'b1);
   endtask

   task automatic test_register_extremes();
      run_register_phase(16'd0, 16'hFFFF, 13'd8191, 13'd8191);
      run_register_phase(16'd0, 16'd0, 13'd1, 13'd1);
      run_register_phase(16'hFFFF, 16'd4096, 13'd640, 13'd480);
      run_register_phase(16'd1000, 16'd1, 13'd0, 13'd0);
      run_register_phase(16'd30000, 16'd8192, 13'd8191, 13'd1);
   endtask

   // A long receiver hold-off fills the pipeline until the input stalls.
   task automatic test_backpressure();
      wait_for_idle();
      program_registers(16'd100, 16'd4096, 13'd640, 13'd640);
      quiet = 1'b1;
      hold_offs_asked++;
      for (int i = 0; i < 16; i++)
         send_single(random_coord(), random_coord(), random_coord(), random_coord(),
                     16'hFFFF - SCORE_W'(i), 1'b0);
      wait_for_idle();
      quiet = 1'b0;
   endtask

   // Anchor numbers count every closed anchor, shown or not, and restart with a new frame.
   task automatic test_anchor_numbering();
      logic [SCORE_W-1:0] score;
      wait_for_idle();
      program_registers(16'hF000, 16'd4096, 13'd640, 13'd640);
      for (int n = 0; n < ANCHOR_RUN; n++) begin
         if (n % 7 == 0 || n >= ANCHOR_RUN - 4)
            score = 16'hFFFF;
         else
            score = SCORE_W'($urandom_range(0, 16'hF000));
         send_single(random_coord(), random_coord(), random_coord(), random_coord(), score,
                     n == 0 || n == ANCHOR_RUN / 2);
      end
   endtask

   task automatic test_random_frames();
      logic [SCORE_W-1:0] thr;
      logic [RATIO_W-1:0] ratio;
      logic [PIXEL_W-1:0] w, h;
      int phase_end;
      for (int phase = 0; phase < 6; phase++) begin
         wait_for_idle();
         thr = ($urandom_range(0, 3) == 0) ? SCORE_W'($urandom)
                                           : SCORE_W'($urandom_range(8000, 50000));
         ratio = ($urandom_range(0, 7) == 0) ? RATIO_W'($urandom)
                                             : RATIO_W'($urandom_range(1024, 16384));
         w = ($urandom_range(0, 7) == 0) ? 13'd8191 : PIXEL_W'($urandom_range(1, 4000));
         h = ($urandom_range(0, 7) == 0) ? 13'd8191 : PIXEL_W'($urandom_range(1, 4000));
         program_registers(thr, ratio, w, h);
         if (phase == 5)
            quiet = 1'b1;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0)
               send_noise_item();
            else
               send_anchor(($urandom_range(0, 29) == 0) ? $urandom_range(120, 135)
                                                       : $urandom_range(1, 8),
                           $urandom_range(0, 15) == 0, $urandom_range(0, 9) != 0);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_missing_first();
      test_directed_cases();
      test_class_overflow();
      test_register_extremes();
      test_backpressure();
      test_anchor_numbering();
      test_random_frames();
      wait_for_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
